>>> rtl/gms_pkg.sv
// ----------------------------------------------------------------------------
// gms_pkg
// Shared types and constants of the grouped median selector: state codes,
// group numbering and the category mask of each population group.
// ----------------------------------------------------------------------------
`default_nettype none

package gms_pkg;

  // record categories, index is is_male*2 + employed
  localparam int NUM_CATS   = 4;
  localparam int NUM_GROUPS = 7;
  localparam int GROUP_W    = 3;
  localparam int AGE_W      = 8;

  localparam logic [GROUP_W-1:0] LAST_GROUP = GROUP_W'(NUM_GROUPS - 1);

  // group codes as they appear on the result channel
  localparam logic [GROUP_W-1:0] GRP_ALL        = 3'd0;
  localparam logic [GROUP_W-1:0] GRP_FEMALE     = 3'd1;
  localparam logic [GROUP_W-1:0] GRP_MALE       = 3'd2;
  localparam logic [GROUP_W-1:0] GRP_EMP_FEMALE = 3'd3;
  localparam logic [GROUP_W-1:0] GRP_UNE_FEMALE = 3'd4;
  localparam logic [GROUP_W-1:0] GRP_EMP_MALE   = 3'd5;
  localparam logic [GROUP_W-1:0] GRP_UNE_MALE   = 3'd6;

  typedef enum logic [2:0] {
    ST_CLEAR,  // clearing pass over the histogram after reset
    ST_LOAD,   // taking records
    ST_FLUSH,  // last record write-back, latch group targets
    ST_WALK,   // sweep of the age rows, clearing behind
    ST_DRAIN,  // last row accumulates
    ST_EMIT    // seven results go out
  } gms_state_t;

  // control from the sequencer to the median unit
  typedef struct packed {
    logic init;   // start of a sweep: load targets, clear accumulators
    logic row_v;  // histogram row on the read port is part of the sweep
  } gms_walk_ctl_t;

  // categories that make up each group, bit c set for category c
  function automatic logic [NUM_CATS-1:0] group_mask(input logic [GROUP_W-1:0] g);
    logic [NUM_CATS-1:0] m;
    unique case (g)
      GRP_ALL:        m = 4'b1111;
      GRP_FEMALE:     m = 4'b0011;
      GRP_MALE:       m = 4'b1100;
      GRP_EMP_FEMALE: m = 4'b0010;
      GRP_UNE_FEMALE: m = 4'b0001;
      GRP_EMP_MALE:   m = 4'b1000;
      GRP_UNE_MALE:   m = 4'b0100;
      default:        m = 4'b0000;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

>>> rtl/grouped_median_select_top.sv
// ----------------------------------------------------------------------------
// grouped_median_select_top
// Median age per population group. Records build a histogram of ages, one
// row per age holding a counter for each (sex, employment) category; the
// last record of a set starts a sweep of the rows that yields seven medians.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                  | tuser  | tlast
//  in_*     | in  | age[7:0], is_male, employed, zeros  | -      | last_record
//  out_*    | out | median_age[7:0], overflow, zeros    | group  | last_result
//
//  records are taken one per cycle while loading; the histogram update is a
//  read-modify-write of one RAM row with forwarding of the previous write
//  after the last record: a flush state, a sweep of the AGE_LEVELS rows and a
//  drain state, then the seven results one per cycle as the sink takes them
//  reset starts a clearing pass over all AGE_LEVELS rows with in_tready low
//  the sweep clears each row behind it, so the next set starts from zero
// ----------------------------------------------------------------------------
`default_nettype none

module grouped_median_select_top
  import gms_pkg::*;
#(
  parameter int MAX_RECORDS = 256,
  parameter int AGE_LEVELS  = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // record channel
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [15:0]        in_tdata,   // age[7:0], is_male, employed
  input  wire logic               in_tlast,
  // result channel
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic      [15:0]        out_tdata,  // median_age[7:0], overflow
  output logic      [GROUP_W-1:0] out_tuser,  // group
  output logic                    out_tlast
);

  localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
  localparam int ROW_W  = NUM_CATS * CNT_W;
  localparam int ADDR_W = $clog2(AGE_LEVELS);
  localparam logic [10:0]       AGE_MAX  = 11'(AGE_LEVELS - 1);
  localparam logic [ADDR_W-1:0] ROW_LAST = ADDR_W'(AGE_LEVELS - 1);
  localparam logic [CNT_W-1:0]  CAP      = CNT_W'(MAX_RECORDS);

  gms_state_t          state_r, state_nxt;
  logic [ADDR_W-1:0]   walk_addr_r, walk_addr_nxt;
  logic [GROUP_W-1:0]  grp_r, grp_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [ROW_W-1:0]    cat_tot_r, cat_tot_nxt;
  logic                ovf_r, ovf_nxt;
  logic                set_done;

  // load pipeline and write forwarding
  logic                ld_v_r;
  logic [ADDR_W-1:0]   ld_addr_r;
  logic [1:0]          ld_cat_r;
  logic                fw_v_r;
  logic [ADDR_W-1:0]   fw_addr_r;
  logic [ROW_W-1:0]    fw_row_r;
  logic                rv_r;
  logic [ADDR_W-1:0]   rage_r;

  logic                in_req;
  logic                out_req;
  logic                store;
  logic [10:0]         age_ext;
  logic [ADDR_W-1:0]   bin_addr;
  logic [1:0]          bin_cat;
  logic [ROW_W-1:0]    row_old;
  logic [ROW_W-1:0]    row_new;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ROW_W-1:0]    ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [ROW_W-1:0]    ram_rdata;

  gms_walk_ctl_t       walk_ctl;
  logic [AGE_W-1:0]    median;

  // request decode, age saturation to the last bin
  assign in_tready = (state_r == ST_LOAD);
  assign in_req    = in_tvalid && in_tready;
  assign out_req   = out_tvalid && out_tready;
  assign age_ext   = 11'(in_tdata[7:0]);
  assign bin_addr  = (age_ext > AGE_MAX) ? ADDR_W'(AGE_MAX) : ADDR_W'(age_ext);
  assign bin_cat   = {in_tdata[8], in_tdata[9]};
  assign store     = in_req && (count_r < CAP);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    walk_addr_nxt = walk_addr_r;
    grp_nxt       = grp_r;
    set_done      = 1'b0;
    walk_ctl      = '0;
    unique case (state_r)
      ST_CLEAR: begin
        walk_addr_nxt = walk_addr_r + 1'b1;
        if (walk_addr_r == ROW_LAST) begin
          walk_addr_nxt = '0;
          state_nxt     = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (in_req && in_tlast) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        walk_ctl.init = 1'b1;
        state_nxt     = ST_WALK;
      end
      ST_WALK: begin
        walk_addr_nxt = walk_addr_r + 1'b1;
        if (walk_addr_r == ROW_LAST) begin
          walk_addr_nxt = '0;
          state_nxt     = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_req) begin
          grp_nxt = grp_r + 1'b1;
          if (grp_r == LAST_GROUP) begin
            grp_nxt   = '0;
            set_done  = 1'b1;
            state_nxt = ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
    walk_ctl.row_v = rv_r;
  end

  // record count, category totals and overflow of the current set
  always_comb begin
    count_nxt   = count_r;
    cat_tot_nxt = cat_tot_r;
    ovf_nxt     = ovf_r;
    if (set_done) begin
      count_nxt   = '0;
      cat_tot_nxt = '0;
      ovf_nxt     = 1'b0;
    end else if (store) begin
      count_nxt = count_r + 1'b1;
      for (int c = 0; c < NUM_CATS; c++) begin
        if (bin_cat == 2'(c)) begin
          cat_tot_nxt[c*CNT_W +: CNT_W] = cat_tot_r[c*CNT_W +: CNT_W] + 1'b1;
        end
      end
    end else if (in_req) begin
      ovf_nxt = 1'b1;
    end
  end

  // row update with forwarding of the write from the cycle before
  always_comb begin
    row_old = (fw_v_r && (fw_addr_r == ld_addr_r)) ? fw_row_r : ram_rdata;
    row_new = row_old;
    for (int c = 0; c < NUM_CATS; c++) begin
      if (ld_cat_r == 2'(c)) begin
        row_new[c*CNT_W +: CNT_W] = row_old[c*CNT_W +: CNT_W] + 1'b1;
      end
    end
  end

  // histogram port steering: clearing pass and sweep write zeros
  always_comb begin
    priority if (state_r == ST_CLEAR || state_r == ST_WALK) begin
      ram_we    = 1'b1;
      ram_waddr = walk_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = ld_v_r;
      ram_waddr = ld_addr_r;
      ram_wdata = row_new;
    end
    ram_raddr = (state_r == ST_WALK) ? walk_addr_r : bin_addr;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      walk_addr_r <= '0;
      grp_r       <= '0;
      count_r     <= '0;
      cat_tot_r   <= '0;
      ovf_r       <= 1'b0;
      ld_v_r      <= 1'b0;
      fw_v_r      <= 1'b0;
      rv_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      walk_addr_r <= walk_addr_nxt;
      grp_r       <= grp_nxt;
      count_r     <= count_nxt;
      cat_tot_r   <= cat_tot_nxt;
      ovf_r       <= ovf_nxt;
      ld_v_r      <= store;
      fw_v_r      <= ld_v_r;
      rv_r        <= (state_r == ST_WALK);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ld_addr_r <= bin_addr;
    ld_cat_r  <= bin_cat;
    fw_addr_r <= ld_addr_r;
    fw_row_r  <= row_new;
    rage_r    <= walk_addr_r;
  end

  gms_ram #(
    .WIDTH (ROW_W),
    .DEPTH (AGE_LEVELS)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gms_median #(
    .CNT_W  (CNT_W),
    .ADDR_W (ADDR_W)
  ) u_median (
    .clk     (clk),
    .ctl     (walk_ctl),
    .cat_tot (cat_tot_r),
    .row     (ram_rdata),
    .row_age (rage_r),
    .sel     (grp_r),
    .median  (median)
  );

  // result channel
  assign out_tvalid = (state_r == ST_EMIT);
  assign out_tdata  = {7'b0, ovf_r, median};
  assign out_tuser  = grp_r;
  assign out_tlast  = (grp_r == LAST_GROUP);

endmodule

`default_nettype wire

>>> rtl/gms_ram.sv
// ----------------------------------------------------------------------------
// gms_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data (read returns the old contents on a same-address write).
// ----------------------------------------------------------------------------
`default_nettype none

module gms_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/gms_median.sv
// ----------------------------------------------------------------------------
// gms_median
// Median accumulators for the seven groups. One histogram row (all four
// categories at one age) arrives per cycle; each group adds its categories
// and catches the first age at which the running count passes half its total.
// ----------------------------------------------------------------------------
`default_nettype none

module gms_median
  import gms_pkg::*;
#(
  parameter int CNT_W  = 9,
  parameter int ADDR_W = 8
) (
  input  wire logic                      clk,
  input  wire gms_walk_ctl_t             ctl,
  input  wire logic [NUM_CATS*CNT_W-1:0] cat_tot,
  input  wire logic [NUM_CATS*CNT_W-1:0] row,
  input  wire logic [ADDR_W-1:0]         row_age,
  input  wire logic [GROUP_W-1:0]        sel,
  output logic      [AGE_W-1:0]          median
);

  logic [CNT_W-1:0]    seen_r   [NUM_GROUPS];
  logic [CNT_W-1:0]    target_r [NUM_GROUPS];
  logic                found_r  [NUM_GROUPS];
  logic [AGE_W-1:0]    med_r    [NUM_GROUPS];

  logic [NUM_CATS-1:0] mask_w   [NUM_GROUPS];
  logic [CNT_W-1:0]    tot_w    [NUM_GROUPS];
  logic [CNT_W-1:0]    add_w    [NUM_GROUPS];
  logic [CNT_W-1:0]    sum_w    [NUM_GROUPS];
  logic                hit_w    [NUM_GROUPS];

  // group totals, row contribution and pass test
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      mask_w[g] = group_mask(GROUP_W'(g));
      tot_w[g]  = '0;
      add_w[g]  = '0;
      for (int c = 0; c < NUM_CATS; c++) begin
        if (mask_w[g][c]) begin
          tot_w[g] = tot_w[g] + cat_tot[c*CNT_W +: CNT_W];
          add_w[g] = add_w[g] + row[c*CNT_W +: CNT_W];
        end
      end
      sum_w[g] = seen_r[g] + add_w[g];
      hit_w[g] = ctl.row_v && !found_r[g] && (sum_w[g] > target_r[g]);
    end
  end

  // accumulators; an empty group never hits and keeps median 0
  always_ff @(posedge clk) begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (ctl.init) begin
        seen_r[g]   <= '0;
        found_r[g]  <= 1'b0;
        med_r[g]    <= '0;
        target_r[g] <= tot_w[g] >> 1;
      end else if (ctl.row_v) begin
        seen_r[g] <= sum_w[g];
        if (hit_w[g]) begin
          found_r[g] <= 1'b1;
          med_r[g]   <= AGE_W'(row_age);
        end
      end
    end
  end

  assign median = med_r[sel];

endmodule

`default_nettype wire

>>> tb/sv/grouped_median_select_top_tb.sv
// ----------------------------------------------------------------------------
// grouped_median_select_top_tb
// Self-checking bench for the grouped median selector. Record sets are sent
// on the input stream while a local histogram model predicts the seven group
// medians of each set. Results are checked in order, field by field. Both
// sides idle at random, and one long sink stall backs the block up.
// ----------------------------------------------------------------------------
`default_nettype none

module grouped_median_select_top_tb;
  import gms_pkg::*;

  localparam int MAX_RECORDS  = 256;
  localparam int AGE_LEVELS   = 256;
  localparam int IDLE_LIMIT   = 5000;
  localparam int LONG_HOLD    = 600;
  localparam int TAIL_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 24;

  typedef struct {
    logic [GROUP_W-1:0] grp;
    logic [AGE_W-1:0]   median;
    logic               ovf;
    logic               last;
  } median_result_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [15:0]        in_tdata   = '0;
  logic               in_tlast   = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [15:0]        out_tdata;
  logic [GROUP_W-1:0] out_tuser;
  logic               out_tlast;

  // categories behind each group code, bit c for category is_male*2+employed
  logic [NUM_CATS-1:0] group_cats [NUM_GROUPS] =
    '{4'b1111, 4'b0011, 4'b1100, 4'b0010, 4'b0001, 4'b1000, 4'b0100};

  // model state of the current set
  int unsigned age_hist [NUM_CATS][AGE_LEVELS];
  int unsigned set_count    = 0;
  logic        set_dropped  = 1'b0;

  median_result_t medians_due [$];
  int unsigned    mismatches    = 0;
  int unsigned    records_sent  = 0;
  int unsigned    idle_cycles   = 0;
  bit             no_idle       = 1'b0;
  bit             hold_pending  = 1'b0;

  grouped_median_select_top #(
    .MAX_RECORDS (MAX_RECORDS),
    .AGE_LEVELS  (AGE_LEVELS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // age[7:0], is_male, employed
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // median_age[7:0], overflow
    .out_tuser  (out_tuser),  // group
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // upper median of the categories in cats, 0 when none are held
  function automatic logic [AGE_W-1:0] upper_median(logic [NUM_CATS-1:0] cats);
    int unsigned total;
    int unsigned seen;
    int unsigned target;
    total = 0;
    seen  = 0;
    for (int c = 0; c < NUM_CATS; c++)
      if (cats[c])
        for (int a = 0; a < AGE_LEVELS; a++) total += age_hist[c][a];
    if (total == 0) return '0;
    target = total / 2;
    for (int a = 0; a < AGE_LEVELS; a++) begin
      for (int c = 0; c < NUM_CATS; c++)
        if (cats[c]) seen += age_hist[c][a];
      if (seen > target) return AGE_W'(a);
    end
    return AGE_W'(AGE_LEVELS - 1);
  endfunction

  // account one accepted record, predict the medians on the last one
  task automatic tally_record(logic [AGE_W-1:0] age, logic male, logic emp, logic last);
    int unsigned cat;
    int unsigned bin;
    median_result_t r;
    cat = {male, emp};
    bin = (age > AGE_LEVELS - 1) ? AGE_LEVELS - 1 : age;
    if (set_count >= MAX_RECORDS) begin
      set_dropped = 1'b1;
    end else begin
      age_hist[cat][bin]++;
      set_count++;
    end
    if (last) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        r.grp    = GROUP_W'(g);
        r.median = upper_median(group_cats[g]);
        r.ovf    = set_dropped;
        r.last   = (GROUP_W'(g) == LAST_GROUP);
        medians_due.push_back(r);
      end
      foreach (age_hist[c, a]) age_hist[c][a] = 0;
      set_count   = 0;
      set_dropped = 1'b0;
    end
  endtask

  // offer one record and wait until the block takes it
  task automatic push_record(logic [AGE_W-1:0] age, logic male, logic emp, logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, emp, male, age};
    in_tlast  <= last;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    tally_record(age, male, emp, last);
    records_sent++;
  endtask

  // one set of n records with random categories and ages in [lo, hi]
  task automatic send_set(int n, int lo, int hi);
    for (int i = 0; i < n; i++)
      push_record(AGE_W'($urandom_range(lo, hi)), 1'($urandom), 1'($urandom), i == n - 1);
  endtask

  // single records at both age extremes, one per category
  task automatic test_single_records();
    push_record(8'd0,   1'b0, 1'b0, 1'b1);
    push_record(8'd255, 1'b1, 1'b1, 1'b1);
    push_record(8'd255, 1'b0, 1'b1, 1'b1);
    push_record(8'd0,   1'b1, 1'b0, 1'b1);
  endtask

  // every group filled, even and odd counts, duplicates, empty groups
  task automatic test_group_split();
    // one record per category
    push_record(8'd40,  1'b0, 1'b0, 1'b0);
    push_record(8'd30,  1'b0, 1'b1, 1'b0);
    push_record(8'd20,  1'b1, 1'b0, 1'b0);
    push_record(8'd10,  1'b1, 1'b1, 1'b1);
    // even count takes the upper median
    push_record(8'd20,  1'b0, 1'b1, 1'b0);
    push_record(8'd10,  1'b0, 1'b1, 1'b1);
    // duplicates and extremes, males only so female groups stay empty
    push_record(8'd255, 1'b1, 1'b0, 1'b0);
    push_record(8'd77,  1'b1, 1'b0, 1'b0);
    push_record(8'd77,  1'b1, 1'b1, 1'b0);
    push_record(8'd0,   1'b1, 1'b1, 1'b0);
    push_record(8'd77,  1'b1, 1'b0, 1'b1);
    // alternating bit patterns
    push_record(8'hAA,  1'b0, 1'b0, 1'b0);
    push_record(8'h55,  1'b1, 1'b1, 1'b0);
    push_record(8'hAA,  1'b1, 1'b0, 1'b0);
    push_record(8'h55,  1'b0, 1'b1, 1'b1);
  endtask

  // capacity reached exactly, then dropped records including the last one
  task automatic test_capacity();
    send_set(MAX_RECORDS + 4, 0, 255);
  endtask

  // long sink stall while records keep coming
  task automatic test_back_pressure();
    hold_pending = 1'b1;
    for (int i = 0; i < 3; i++) send_set($urandom_range(3, 9), 0, 255);
  endtask

  // random small sets, some with narrow age windows
  task automatic test_random_sets();
    int unsigned start;
    int n;
    int lo;
    int pick;
    start = records_sent;
    while (records_sent - start < RANDOM_ITEMS) begin
      no_idle = (records_sent - start < RANDOM_ITEMS / 3);
      pick = $urandom_range(0, 9);
      if (pick < 7) n = $urandom_range(1, 6);
      else          n = $urandom_range(7, 12);
      if ($urandom_range(0, 1)) begin
        send_set(n, 0, 255);
      end else begin
        lo = $urandom_range(0, 250);
        send_set(n, lo, lo + 5);
      end
    end
    no_idle = 1'b0;
  endtask

  // result sink: random ready gaps plus the requested long stall
  initial begin : result_sink
    int gap;
    forever begin
      if (hold_pending) begin
        gap = LONG_HOLD;
        hold_pending = 1'b0;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 6);
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_tvalid && out_tready));
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_result
    median_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (medians_due.size() == 0) begin
        $display("%0t: unexpected result group %0d median %0d overflow %0b last %0b",
                 $time, out_tuser, out_tdata[7:0], out_tdata[8], out_tlast);
        mismatches++;
      end else begin
        want = medians_due.pop_front();
        if (out_tuser !== want.grp) begin
          $display("%0t: group expected %0d actual %0d", $time, want.grp, out_tuser);
          mismatches++;
        end
        if (out_tdata[7:0] !== want.median) begin
          $display("%0t: median of group %0d expected %0d actual %0d",
                   $time, want.grp, want.median, out_tdata[7:0]);
          mismatches++;
        end
        if (out_tdata[8] !== want.ovf) begin
          $display("%0t: overflow of group %0d expected %0b actual %0b",
                   $time, want.grp, want.ovf, out_tdata[8]);
          mismatches++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: last of group %0d expected %0b actual %0b",
                   $time, want.grp, want.last, out_tlast);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any request moving
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_single_records();
    test_group_split();
    test_capacity();
    test_back_pressure();
    test_random_sets();
    in_tvalid <= 1'b0;
    while (medians_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> grouped_median_select_top.f
rtl/gms_pkg.sv
rtl/gms_ram.sv
rtl/gms_median.sv
rtl/grouped_median_select_top.sv
tb/sv/grouped_median_select_top_tb.sv
